// File: src/urs_pkg.sv
// ----------------------------------------------------------------------------
// urs_pkg
// Types and constants shared by the ultrasonic ranger scheduler sources.
// ----------------------------------------------------------------------------
package urs_pkg;

  // sequencing phase of the sensor currently served
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_MEAS = 2'd2
  } phase_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MAX_ECHO = 2'd0,
    CFG_TIMEOUT  = 2'd1,
    CFG_TRIGGER  = 2'd2,
    CFG_FAULT    = 2'd3
  } cfg_idx_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TIME_W     = 16;
  localparam int unsigned TRIG_LEN_W = 8;
  localparam int unsigned DIST_W     = 16;

  localparam logic [TIME_W-1:0]     RST_MAX_ECHO = 16'd25000;
  localparam logic [TIME_W-1:0]     RST_TIMEOUT  = 16'd30000;
  localparam logic [TRIG_LEN_W-1:0] RST_TRIGGER  = 8'd10;
  localparam logic [DIST_W-1:0]     RST_FAULT    = 16'hFFFF;

  localparam logic [TIME_W-1:0] TIME_MAX = 16'hFFFF;

  // width * 343 / 2000 as a reciprocal multiply: ceil(343 * 2^27 / 2000),
  // exact for every 16-bit width
  localparam int unsigned      DIST_MUL_W = 25;
  localparam logic [24:0]      DIST_MUL   = 25'd23018341;
  localparam int unsigned      DIST_SHIFT = 27;
  localparam int unsigned      PROD_W     = TIME_W + DIST_MUL_W;

endpackage

// File: src/urs_if.sv
// ----------------------------------------------------------------------------
// urs_in_if / urs_out_if
// Valid/ready channels for echo samples and ranging results.
// ----------------------------------------------------------------------------
interface urs_in_if #(
  parameter int unsigned ECHO_W = 3
);
  logic              valid;
  logic              ready;
  logic [ECHO_W-1:0] echo_levels;

  modport source (output valid, output echo_levels, input ready);
  modport sink   (input valid, input echo_levels, output ready);
endinterface

interface urs_out_if #(
  parameter int unsigned ECHO_W = 3,
  parameter int unsigned IDX_W  = 2
);
  logic                        valid;
  logic                        ready;
  logic [ECHO_W-1:0]           trig_levels;
  logic                        reading_valid;
  logic [IDX_W-1:0]            sensor_index;
  logic [urs_pkg::DIST_W-1:0]  distance_mm;
  logic                        is_fault;
  logic                        round_done;

  modport source (output valid, output trig_levels, output reading_valid,
                  output sensor_index, output distance_mm, output is_fault,
                  output round_done, input ready);
  modport sink   (input valid, input trig_levels, input reading_valid,
                  input sensor_index, input distance_mm, input is_fault,
                  input round_done, output ready);
endinterface

// File: src/ultrasonic_ranger_scheduler.sv
// ----------------------------------------------------------------------------
// ultrasonic_ranger_scheduler
// Round-robin trigger and echo timing for a bank of ultrasonic rangers.
// ----------------------------------------------------------------------------
// Each input word is one microsecond sample of all echo lines; each accepted
// word yields exactly one result word via both stages, and a new sample is
// taken every cycle while the result side keeps up. The first stage runs the
// phase sequencer (idle, trigger, measure), edge detection and the timeout
// check and registers the echo width; the second stage scales the width to
// millimetres with one reciprocal multiply and holds the result word. A
// stalled result side backs up through both stages to the sample input.
// Configuration is written through a plain write port and must only change
// while no sample is in flight.
module ultrasonic_ranger_scheduler #(
  parameter int unsigned SENSOR_COUNT = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [urs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [urs_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  urs_in_if.sink                            sample_i,
  urs_out_if.source                         result_o
);

  localparam int unsigned ECHO_W  = SENSOR_COUNT;
  localparam int unsigned IDX_W   = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_SENSOR = IDX_W'(SENSOR_COUNT - 1);

  typedef struct packed {
    logic [ECHO_W-1:0]           trig;
    logic                        done;
    logic [IDX_W-1:0]            idx;
    logic                        fault;
    logic                        round;
    logic [urs_pkg::TIME_W-1:0]  width;
  } stage_t;

  // configuration
  logic [urs_pkg::TIME_W-1:0]     max_echo_q;
  logic [urs_pkg::TIME_W-1:0]     timeout_q;
  logic [urs_pkg::TRIG_LEN_W-1:0] trigger_q;
  logic [urs_pkg::DIST_W-1:0]     fault_code_q;

  // sequencer state
  urs_pkg::phase_e            phase_q, phase_d;
  logic [IDX_W-1:0]           active_q, active_d;
  logic [urs_pkg::TIME_W-1:0] elapsed_q, elapsed_d;
  logic [urs_pkg::TIME_W-1:0] rise_at_q, rise_at_d;
  logic                       rise_seen_q, rise_seen_d;
  logic [ECHO_W-1:0]          prev_echo_q;

  // pipeline
  logic                       s1_valid_q;
  stage_t                     s1_q, s1_d;
  logic                       out_valid_q;
  logic [ECHO_W-1:0]          out_trig_q;
  logic                       out_done_q;
  logic [IDX_W-1:0]           out_idx_q;
  logic [urs_pkg::DIST_W-1:0] out_dist_q;
  logic                       out_fault_q;
  logic                       out_round_q;

  logic                       in_fire;
  logic                       s2_free;
  logic                       s1_move;
  logic                       echo_now;
  logic                       echo_before;
  logic [urs_pkg::TIME_W-1:0] count_inc;
  logic [urs_pkg::TIME_W-1:0] width;
  logic                       fall;
  logic                       done;
  logic                       fault;
  logic [urs_pkg::PROD_W-1:0] product;
  logic [urs_pkg::DIST_W-1:0] scaled;
  logic [urs_pkg::DIST_W-1:0] dist_mm;

  assign s2_free        = !out_valid_q || result_o.ready;
  assign s1_move        = s1_valid_q && s2_free;
  assign sample_i.ready = !s1_valid_q || s2_free;
  assign in_fire        = sample_i.valid && sample_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_echo_q   <= urs_pkg::RST_MAX_ECHO;
      timeout_q    <= urs_pkg::RST_TIMEOUT;
      trigger_q    <= urs_pkg::RST_TRIGGER;
      fault_code_q <= urs_pkg::RST_FAULT;
    end else if (cfg_we_i) begin
      unique case (urs_pkg::cfg_idx_e'(cfg_idx_i))
        urs_pkg::CFG_MAX_ECHO: max_echo_q   <= cfg_data_i;
        urs_pkg::CFG_TIMEOUT:  timeout_q    <= cfg_data_i;
        urs_pkg::CFG_TRIGGER:  trigger_q    <= cfg_data_i[urs_pkg::TRIG_LEN_W-1:0];
        urs_pkg::CFG_FAULT:    fault_code_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign echo_now    = |((sample_i.echo_levels >> active_q) & ECHO_W'(1));
  assign echo_before = |((prev_echo_q >> active_q) & ECHO_W'(1));

  // phase sequencer and first result stage
  always_comb begin
    phase_d     = phase_q;
    active_d    = active_q;
    elapsed_d   = elapsed_q;
    rise_at_d   = rise_at_q;
    rise_seen_d = rise_seen_q;
    count_inc   = elapsed_q + urs_pkg::TIME_W'(1);
    width       = '0;
    fall        = 1'b0;
    done        = 1'b0;
    fault       = 1'b0;
    s1_d        = '0;

    unique case (phase_q)
      urs_pkg::PH_TRIG: begin
        s1_d.trig = ECHO_W'(1) << active_q;
        if (count_inc >= urs_pkg::TIME_W'(trigger_q)) begin
          phase_d     = urs_pkg::PH_MEAS;
          elapsed_d   = '0;
          rise_at_d   = '0;
          rise_seen_d = 1'b0;
        end else begin
          elapsed_d = count_inc;
        end
      end
      urs_pkg::PH_MEAS: begin
        // counter sticks at full scale
        if (elapsed_q == urs_pkg::TIME_MAX) begin
          count_inc = elapsed_q;
        end
        elapsed_d = count_inc;
        width     = count_inc - rise_at_q;
        if (echo_now && !echo_before) begin
          rise_at_d   = count_inc;
          rise_seen_d = 1'b1;
        end else if (!echo_now && echo_before) begin
          fall  = 1'b1;
          done  = 1'b1;
          fault = !rise_seen_q || (width == '0) || (width >= max_echo_q);
        end
        if (!fall && (count_inc > timeout_q || count_inc == urs_pkg::TIME_MAX)) begin
          done  = 1'b1;
          fault = 1'b1;
        end
        if (done) begin
          s1_d.idx    = active_q;
          s1_d.round  = (active_q >= LAST_SENSOR);
          active_d    = s1_d.round ? '0 : active_q + IDX_W'(1);
          phase_d     = urs_pkg::PH_IDLE;
          elapsed_d   = '0;
          rise_seen_d = 1'b0;
        end
      end
      default: begin
        phase_d   = urs_pkg::PH_TRIG;
        elapsed_d = '0;
      end
    endcase

    s1_d.done  = done;
    s1_d.fault = fault;
    s1_d.width = width;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= urs_pkg::PH_IDLE;
      active_q    <= '0;
      elapsed_q   <= '0;
      rise_at_q   <= '0;
      rise_seen_q <= 1'b0;
      prev_echo_q <= '0;
    end else if (in_fire) begin
      phase_q     <= phase_d;
      active_q    <= active_d;
      elapsed_q   <= elapsed_d;
      rise_at_q   <= rise_at_d;
      rise_seen_q <= rise_seen_d;
      prev_echo_q <= sample_i.echo_levels;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      s1_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
  end

  // millimetre scaling
  assign product = urs_pkg::PROD_W'(s1_q.width) * urs_pkg::PROD_W'(urs_pkg::DIST_MUL);
  assign scaled  = urs_pkg::DIST_W'(product >> urs_pkg::DIST_SHIFT);

  always_comb begin
    if (!s1_q.done) begin
      dist_mm = '0;
    end else if (s1_q.fault) begin
      dist_mm = fault_code_q;
    end else begin
      dist_mm = scaled;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_trig_q  <= s1_q.trig;
      out_done_q  <= s1_q.done;
      out_idx_q   <= s1_q.idx;
      out_dist_q  <= dist_mm;
      out_fault_q <= s1_q.fault;
      out_round_q <= s1_q.round;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.trig_levels   = out_trig_q;
  assign result_o.reading_valid = out_done_q;
  assign result_o.sensor_index  = out_idx_q;
  assign result_o.distance_mm   = out_dist_q;
  assign result_o.is_fault      = out_fault_q;
  assign result_o.round_done    = out_round_q;

endmodule

// File: dv/ultrasonic_ranger_scheduler_test.sv
// ----------------------------------------------------------------------------
// ultrasonic_ranger_scheduler_test
// Streams echo samples into the ranger scheduler and checks every result word
// against a cycle-true model of the round-robin trigger/measure sequencer.
// Directed sequences cover the edge and timeout corner cases, then random echo
// pulse trains run under several register settings and handshake idling modes.
// ----------------------------------------------------------------------------
module ultrasonic_ranger_scheduler_test;
  import urs_pkg::*;

  localparam int unsigned NSENS     = 3;
  localparam int unsigned SOUND_NUM = 343;
  localparam int unsigned SOUND_DEN = 2000;

  typedef struct packed {
    logic [2:0]        trig;
    logic              reading;
    logic [1:0]        sensor;
    logic [DIST_W-1:0] mm;
    logic              fault;
    logic              round;
  } ranging_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  cfg_idx_e              cfg_idx = CFG_MAX_ECHO;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  urs_in_if  #(.ECHO_W(3))              smp_if ();
  urs_out_if #(.ECHO_W(3), .IDX_W(2))   res_if ();

  ultrasonic_ranger_scheduler #(
    .SENSOR_COUNT(NSENS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .sample_i   (smp_if),
    .result_o   (res_if)
  );

  always #5 clk_i = ~clk_i;

  // model state and register copies
  phase_e            ph;
  logic [1:0]        act;
  logic [TIME_W-1:0] el;
  logic [TIME_W-1:0] rise_at;
  logic              rise_seen;
  logic [2:0]        prev_echo;
  logic [TIME_W-1:0] max_echo;
  logic [TIME_W-1:0] tmo;
  logic [7:0]        trig_len;
  logic [DIST_W-1:0] fault_val;

  ranging_t readings_q[$];
  ranging_t last_pred;
  int       mismatches = 0;
  int       src_idle = 0;
  int       snk_idle = 0;
  int       hold_left = 0;

  // echo pulse generator
  logic [2:0] gen_lvl = '0;
  int         gen_left[3] = '{0, 0, 0};
  int         hi_max = 10;
  int         lo_max = 10;
  int         noise_pct = 10;

  function automatic ranging_t range_step(logic [2:0] echo);
    ranging_t          r;
    logic              now_b;
    logic              was_b;
    logic [TIME_W-1:0] width;
    logic [31:0]       scaled;
    r = '0;
    case (ph)
      PH_TRIG: begin
        r.trig = 3'b001 << act;
        el = el + 16'd1;
        if (el >= {8'd0, trig_len}) begin
          ph = PH_MEAS;
          el = '0;
          rise_at = '0;
          rise_seen = 1'b0;
        end
      end
      PH_MEAS: begin
        now_b = echo[act];
        was_b = prev_echo[act];
        if (el != TIME_MAX) el = el + 16'd1;
        if (now_b && !was_b) begin
          rise_at = el;
          rise_seen = 1'b1;
        end else if (!now_b && was_b) begin
          r.reading = 1'b1;
          if (rise_seen) begin
            width = el - rise_at;
            if (width > 0 && width < max_echo) begin
              scaled = (32'(width) * SOUND_NUM) / SOUND_DEN;
              r.mm = scaled[DIST_W-1:0];
            end else begin
              r.fault = 1'b1;
            end
          end else begin
            r.fault = 1'b1;
          end
        end
        // a fall on the timeout sample still counts as a normal reading
        if (!r.reading && (el > tmo || el == TIME_MAX)) begin
          r.reading = 1'b1;
          r.fault = 1'b1;
        end
        if (r.reading) begin
          if (r.fault) r.mm = fault_val;
          r.sensor = act;
          r.round = (act >= 2'(NSENS - 1));
          act = r.round ? 2'd0 : act + 2'd1;
          ph = PH_IDLE;
          el = '0;
          rise_seen = 1'b0;
        end
      end
      default: begin
        ph = PH_TRIG;
        el = '0;
      end
    endcase
    prev_echo = echo;
    return r;
  endfunction

  function automatic logic [2:0] next_echo();
    logic [2:0] lvl;
    for (int i = 0; i < 3; i++) begin
      if (gen_left[i] == 0) begin
        gen_lvl[i] = ~gen_lvl[i];
        gen_left[i] = gen_lvl[i] ? $urandom_range(hi_max, 1) : $urandom_range(lo_max, 1);
      end
      gen_left[i]--;
    end
    lvl = gen_lvl;
    if ($urandom_range(99) < noise_pct) lvl = 3'($urandom);
    return lvl;
  endfunction

  // called at a falling edge, returns at a falling edge with the word taken
  task automatic send_sample(logic [2:0] lvl);
    while ($urandom_range(99) < src_idle) begin
      smp_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    smp_if.valid <= 1'b1;
    smp_if.echo_levels <= lvl;
    @(posedge clk_i);
    while (!smp_if.ready) @(posedge clk_i);
    last_pred = range_step(lvl);
    readings_q.push_back(last_pred);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    smp_if.valid <= 1'b0;
    while (readings_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      CFG_MAX_ECHO: max_echo = val;
      CFG_TIMEOUT:  tmo = val;
      CFG_TRIGGER:  trig_len = val[7:0];
      CFG_FAULT:    fault_val = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic configure(logic [15:0] me, logic [15:0] tm, logic [7:0] tr, logic [15:0] fc);
    drain_results();
    write_reg(CFG_MAX_ECHO, me);
    write_reg(CFG_TIMEOUT, tm);
    write_reg(CFG_TRIGGER, {8'd0, tr});
    write_reg(CFG_FAULT, fc);
  endtask

  task automatic send_run(logic [2:0] lvl, int n);
    repeat (n) send_sample(lvl);
  endtask

  task automatic run_to_measure(logic [2:0] lvl);
    while (ph != PH_MEAS) send_sample(lvl);
  endtask

  task automatic run_to_reading(logic [2:0] lvl);
    do send_sample(lvl); while (!last_pred.reading);
  endtask

  // default registers: long trigger, one clean echo
  task automatic test_reset_values();
    run_to_measure(3'b000);
    send_run(3'b000, 2);
    send_run(3'b111, 200);
    send_sample(3'b000);
  endtask

  task automatic test_special_cases();
    configure(16'd7, 16'd8, 8'd0, 16'h0000);
    // echo already high when measuring starts, so the fall has no rise
    run_to_measure(3'b111);
    send_run(3'b111, 3);
    send_sample(3'b000);
    // fall lands on the timeout sample, width just under the limit
    run_to_measure(3'b000);
    send_run(3'b000, 2);
    send_run(3'b111, 6);
    send_sample(3'b000);
    // width equal to the limit
    run_to_measure(3'b000);
    send_sample(3'b000);
    send_run(3'b111, 7);
    send_sample(3'b000);
    // no echo at all
    run_to_reading(3'b000);
  endtask

  // long receiver stall fills the pipe, then a full drain before going on
  task automatic test_backpressure();
    int saved;
    saved = src_idle;
    src_idle = 0;
    hold_left = 300;
    repeat (60) send_sample(next_echo());
    smp_if.valid <= 1'b0;
    while (readings_q.size() != 0) @(negedge clk_i);
    repeat (40) send_sample(next_echo());
    src_idle = saved;
  endtask

  task automatic test_random(int per_phase);
    logic [15:0] me;
    logic [15:0] tm;
    logic [7:0]  tr;
    logic [15:0] fc;
    for (int p = 0; p < 12; p++) begin
      if (p < 4) begin
        src_idle = 31;
        snk_idle = 54;
      end else if (p < 8) begin
        src_idle = 54;
        snk_idle = 31;
      end else begin
        src_idle = 0;
        snk_idle = 0;
      end
      me = 16'($urandom_range(60, 2));
      tm = 16'($urandom_range(90, 1));
      tr = 8'($urandom_range(12, 1));
      fc = 16'($urandom);
      case (p)
        1: me = 16'd0;
        2: begin
          me = 16'hFFFF;
          tm = 16'hFFFE;
        end
        3: tr = 8'd255;
        4: tm = 16'd0;
        5: fc = 16'h0000;
        6: me = 16'd1;
        7: tr = 8'd0;
        8: fc = 16'hFFFF;
        9: tm = 16'hFFFF;
        10: begin
          tr = 8'd1;
          tm = 16'd1;
        end
        default: ;
      endcase
      configure(me, tm, tr, fc);
      hi_max = $urandom_range(40, 2);
      lo_max = $urandom_range(30, 2);
      noise_pct = (p % 3 == 0) ? 30 : 8;
      repeat (per_phase) send_sample(next_echo());
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  always @(posedge clk_i) begin
    ranging_t got;
    ranging_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.trig    = res_if.trig_levels;
      got.reading = res_if.reading_valid;
      got.sensor  = res_if.sensor_index;
      got.mm      = res_if.distance_mm;
      got.fault   = res_if.is_fault;
      got.round   = res_if.round_done;
      if (readings_q.size() == 0) begin
        if (mismatches < 10) $display("unexpected result word: %p", got);
        mismatches++;
      end else begin
        want = readings_q.pop_front();
        if (got.trig !== want.trig || got.reading !== want.reading ||
            got.sensor !== want.sensor || got.mm !== want.mm ||
            got.fault !== want.fault || got.round !== want.round) begin
          if (mismatches < 10) begin
            $display("mismatch: trig %0h/%0h valid %0b/%0b sensor %0d/%0d",
                     want.trig, got.trig, want.reading, got.reading,
                     want.sensor, got.sensor);
            $display("          dist %0d/%0d fault %0b/%0b round %0b/%0b (exp/act)",
                     want.mm, got.mm, want.fault, got.fault,
                     want.round, got.round);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    smp_if.valid = 1'b0;
    smp_if.echo_levels = '0;
    res_if.ready = 1'b0;
    ph = PH_IDLE;
    act = '0;
    el = '0;
    rise_at = '0;
    rise_seen = 1'b0;
    prev_echo = '0;
    max_echo = RST_MAX_ECHO;
    tmo = RST_TIMEOUT;
    trig_len = RST_TRIGGER;
    fault_val = RST_FAULT;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    src_idle = 31;
    snk_idle = 54;
    test_reset_values();
    test_special_cases();
    test_backpressure();
    test_random(120);
    smp_if.valid <= 1'b0;
    while (readings_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatches == 0 && readings_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: sim.f
src/urs_pkg.sv
src/urs_if.sv
src/ultrasonic_ranger_scheduler.sv
dv/ultrasonic_ranger_scheduler_test.sv
